// ===== src/palqr_pkg.sv =====
// Types and constants shared by the pitch axis controller and its channels.
`default_nettype none
package palqr_pkg;

    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    localparam logic [7:0]  STARTUP_TICKS = 8'd5;
    localparam logic [10:0] STICK_HI      = 11'd1050;
    localparam logic [10:0] STICK_LO      = 11'd1000;
    localparam logic [11:0] STICK_MID     = 12'd1024;
    localparam logic [27:0] STEP_K        = 28'd312;
    localparam logic [27:0] MOUSE_K       = 28'd624;
    localparam logic [16:0] DEG5          = 17'd357;
    localparam logic [16:0] DEG20         = 17'd1430;
    localparam logic [10:0] DEG15         = 11'd1072;
    localparam logic [27:0] DIV_RECIP     = 28'd256415958;
    localparam logic [61:0] DIV_HALF      = 62'd2195456;
    localparam logic signed [61:0] TORQUE_LIM = 62'sd20480;

    localparam logic [15:0] RST_ANGLE_MIN = 16'hF800;
    localparam logic [15:0] RST_ANGLE_MAX = 16'd2048;
    localparam logic [15:0] RST_STICK_G   = 16'd64;
    localparam logic [15:0] RST_MOUSE_G   = 16'd64;
    localparam logic [15:0] RST_POS_G     = 16'd10240;
    localparam logic [15:0] RST_SPEED_G   = 16'd609;
    localparam logic [15:0] RST_INT_G     = 16'd9830;
    localparam logic [15:0] RST_FF        = 16'd4096;

    typedef enum logic [IDX_W-1:0] {
        CFG_ANGLE_MIN = 3'd0,
        CFG_ANGLE_MAX = 3'd1,
        CFG_STICK_G   = 3'd2,
        CFG_MOUSE_G   = 3'd3,
        CFG_POS_G     = 3'd4,
        CFG_SPEED_G   = 3'd5,
        CFG_INT_G     = 3'd6,
        CFG_FF        = 3'd7
    } t_cfg_idx;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_STEP1 = 16'h0002,
        S_S2    = 16'h0004,
        S_S3    = 16'h0008,
        S_M2    = 16'h0010,
        S_M3    = 16'h0020,
        S_M4    = 16'h0040,
        S_CLAMP = 16'h0080,
        S_I1    = 16'h0100,
        S_I2    = 16'h0200,
        S_I3    = 16'h0400,
        S_DIV   = 16'h0800,
        S_I4    = 16'h1000,
        S_A1    = 16'h2000,
        S_A2    = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

endpackage
`default_nettype wire

// ===== src/palqr_if.sv =====
// Request channels of the pitch axis controller: tick input, result and register write.
`default_nettype none
interface palqr_in_if;
    logic        valid;
    logic        ready;
    logic        link_ok;
    logic        link_started;
    logic        referee_link;
    logic [10:0] stick_ud;
    logic [15:0] mouse_du;
    logic [15:0] mouse_pitch;
    logic        vision_request;
    logic [15:0] vision_pitch;
    logic [15:0] motor_position;
    logic [15:0] motor_speed;

    modport source (
        output valid, link_ok, link_started, referee_link, stick_ud, mouse_du, mouse_pitch,
               vision_request, vision_pitch, motor_position, motor_speed,
        input  ready
    );
    modport sink (
        input  valid, link_ok, link_started, referee_link, stick_ud, mouse_du, mouse_pitch,
               vision_request, vision_pitch, motor_position, motor_speed,
        output ready
    );
endinterface

interface palqr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] torque;
    logic [15:0] target_angle;
    logic        drive_enabled;

    modport source (output valid, torque, target_angle, drive_enabled, input ready);
    modport sink (input valid, torque, target_angle, drive_enabled, output ready);
endinterface

interface palqr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [palqr_pkg::IDX_W-1:0]     index;
    logic [palqr_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/pitch_axis_lqr_integral_control.sv =====
// Pitch axis state feedback controller with a variable integral, one request per tick.
// Usage:
// Each request on i_in is one control tick: link flags, stick and mouse values, an
// optional vision target and the measured motor angle and speed. Each tick returns
// exactly one result request on o_out with the torque, the clamped target angle and
// the drive enable flag. Registers are written through i_cfg, which is always ready;
// write them only while no tick is in flight.
// Timing: one shared 34 by 28 bit multiplier is sequenced over the tick, and the
// integral increment is divided by a constant through a reciprocal multiply on the
// same multiplier. A stick step adds states S_S2 and S_S3 and a mouse step S_M2 to
// S_M4 before S_CLAMP; the result is registered in S_OUT. i_in is ready again in the
// cycle after, so a new tick is taken only once the last one has left S_OUT.
// A finished result waits in the output register; while the receiver stalls, the
// next tick is taken and computed, and it then waits until the output register frees.
// Reset loads the register defaults and clears the target, the integral, the startup
// count and the pending link flag; the torque stays at zero for the first ticks.
`default_nettype none
module pitch_axis_lqr_integral_control (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    palqr_in_if.sink        i_in,
    palqr_out_if.source     o_out,
    palqr_cfg_if.sink       i_cfg
);

    palqr_pkg::t_state r_state;

    logic [15:0] r_amin, r_amax, r_stick_g, r_mouse_g, r_pos_g, r_speed_g, r_int_g, r_ff;

    logic signed [15:0] r_target;
    logic signed [31:0] r_isum;
    logic [7:0]         r_startup;
    logic               r_skip;

    logic        r_link_ok, r_referee, r_vreq;
    logic [10:0] r_stick;
    logic [15:0] r_mouse_du, r_mouse_pitch, r_vision, r_pos, r_speed;

    logic signed [27:0] r_t;
    logic signed [61:0] r_prod;
    logic signed [27:0] r_aux;
    logic signed [16:0] r_err;
    logic [10:0]        r_fade;
    logic [27:0]        r_x;
    logic               r_neg;
    logic signed [39:0] r_acc;

    logic               r_ovalid;
    logic [15:0]        r_torque;
    logic [15:0]        r_tgt_out;
    logic               r_en;

    logic signed [33:0] mul_a;
    logic signed [27:0] mul_b;

    logic signed [11:0] stick_off;
    logic signed [27:0] amin28, amax28;
    logic               move;
    logic signed [61:0] step_s, step_m;
    logic signed [27:0] tv;
    logic signed [16:0] err;
    logic [16:0]        err_mag;
    logic               same;
    logic [10:0]        fade;
    logic [61:0]        div_mag;
    logic [61:0]        div_sum;
    logic signed [28:0] iterm;
    logic signed [32:0] isum33;
    logic signed [31:0] isum32;
    logic signed [61:0] tq_r;
    logic signed [61:0] tq;
    logic               out_load;

    function automatic logic signed [61:0] f_rnd(input logic signed [61:0] v,
                                                 input logic [5:0] sh);
        logic [61:0] mag;
        logic [61:0] q;
        mag = v[61] ? 62'(-v) : 62'(v);
        q = (mag + (62'd1 << (sh - 6'd1))) >> sh;
        return v[61] ? -$signed(q) : $signed(q);
    endfunction

    assign i_in.ready         = (r_state == palqr_pkg::S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_ovalid;
    assign o_out.torque       = r_torque;
    assign o_out.target_angle = r_tgt_out;
    assign o_out.drive_enabled = r_en;

    assign stick_off = $signed({1'b0, r_stick}) - $signed(palqr_pkg::STICK_MID);
    assign amin28    = {{12{r_amin[15]}}, r_amin};
    assign amax28    = {{12{r_amax[15]}}, r_amax};

    always_comb begin
        logic up;
        logic dn;
        up = (((r_stick > palqr_pkg::STICK_HI) && !r_referee) || r_mouse_du[15])
             && (r_t > amin28);
        dn = (((r_stick < palqr_pkg::STICK_LO) && !r_referee)
             || (!r_mouse_du[15] && (r_mouse_du != 16'd0))) && (r_t < amax28);
        move = up || dn;
    end

    assign step_s = f_rnd(r_prod, 6'd16);
    assign step_m = f_rnd(r_prod, 6'd32);

    always_comb begin
        tv = (r_link_ok && r_vreq) ? {{12{r_vision[15]}}, r_vision} : r_t;
        if (tv < amin28) begin
            tv = amin28;
        end
        if (tv > amax28) begin
            tv = amax28;
        end
    end

    always_comb begin
        err     = $signed({r_target[15], r_target}) - $signed({r_pos[15], r_pos});
        err_mag = err[16] ? 17'(-err) : 17'(err);
        same    = ((err > 17'sd0) && (r_isum > 32'sd0)) || (err[16] && r_isum[31]);
        if (!same || (err_mag <= palqr_pkg::DEG5)) begin
            fade = palqr_pkg::DEG15;
        end else if (err_mag <= palqr_pkg::DEG20) begin
            fade = 11'(palqr_pkg::DEG20 - err_mag);
        end else begin
            fade = 11'd0;
        end
    end

    assign div_mag = r_prod[61] ? 62'(-r_prod) : 62'(r_prod);
    assign div_sum = div_mag + palqr_pkg::DIV_HALF;

    always_comb begin
        iterm  = r_neg ? -$signed({1'b0, r_prod[61:34]}) : $signed({1'b0, r_prod[61:34]});
        isum33 = $signed({r_isum[31], r_isum}) + $signed({{4{iterm[28]}}, iterm});
        if (isum33[32] != isum33[31]) begin
            isum32 = isum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            isum32 = isum33[31:0];
        end
    end

    always_comb begin
        tq_r = f_rnd({{22{r_acc[39]}}, r_acc}, 6'd8);
        if (tq_r > palqr_pkg::TORQUE_LIM) begin
            tq = palqr_pkg::TORQUE_LIM;
        end else if (tq_r < -palqr_pkg::TORQUE_LIM) begin
            tq = -palqr_pkg::TORQUE_LIM;
        end else begin
            tq = tq_r;
        end
    end

    assign out_load = (r_state == palqr_pkg::S_OUT) && (!r_ovalid || o_out.ready);

    always_comb begin
        mul_a = 34'sd0;
        mul_b = 28'sd0;
        case (r_state)
            palqr_pkg::S_STEP1: begin
                if (r_mouse_pitch == 16'd0) begin
                    mul_a = $signed({18'd0, r_stick_g});
                    mul_b = {{16{stick_off[11]}}, stick_off};
                end else begin
                    mul_a = $signed({18'd0, r_mouse_g});
                    mul_b = $signed(palqr_pkg::MOUSE_K);
                end
            end
            palqr_pkg::S_S2: begin
                mul_a = r_prod[33:0];
                mul_b = $signed(palqr_pkg::STEP_K);
            end
            palqr_pkg::S_M2: begin
                mul_a = $signed({18'd0, r_stick_g});
                mul_b = {{12{r_mouse_pitch[15]}}, r_mouse_pitch};
            end
            palqr_pkg::S_M3: begin
                mul_a = r_prod[33:0];
                mul_b = r_aux;
            end
            palqr_pkg::S_I1: begin
                mul_a = $signed({18'd0, r_int_g});
                mul_b = {{11{err[16]}}, err};
            end
            palqr_pkg::S_I2: begin
                mul_a = r_prod[33:0];
                mul_b = $signed({17'd0, r_fade});
            end
            palqr_pkg::S_DIV: begin
                mul_a = $signed({6'd0, palqr_pkg::DIV_RECIP});
                mul_b = $signed(r_x);
            end
            palqr_pkg::S_I4: begin
                mul_a = $signed({18'd0, r_pos_g});
                mul_b = {{11{r_err[16]}}, r_err};
            end
            palqr_pkg::S_A1: begin
                mul_a = $signed({18'd0, r_speed_g});
                mul_b = {{12{r_speed[15]}}, r_speed};
            end
            default: begin
                mul_a = 34'sd0;
                mul_b = 28'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amin    <= palqr_pkg::RST_ANGLE_MIN;
            r_amax    <= palqr_pkg::RST_ANGLE_MAX;
            r_stick_g <= palqr_pkg::RST_STICK_G;
            r_mouse_g <= palqr_pkg::RST_MOUSE_G;
            r_pos_g   <= palqr_pkg::RST_POS_G;
            r_speed_g <= palqr_pkg::RST_SPEED_G;
            r_int_g   <= palqr_pkg::RST_INT_G;
            r_ff      <= palqr_pkg::RST_FF;
        end else if (i_cfg.valid) begin
            unique case (palqr_pkg::t_cfg_idx'(i_cfg.index))
                palqr_pkg::CFG_ANGLE_MIN: r_amin    <= i_cfg.data;
                palqr_pkg::CFG_ANGLE_MAX: r_amax    <= i_cfg.data;
                palqr_pkg::CFG_STICK_G:   r_stick_g <= i_cfg.data;
                palqr_pkg::CFG_MOUSE_G:   r_mouse_g <= i_cfg.data;
                palqr_pkg::CFG_POS_G:     r_pos_g   <= i_cfg.data;
                palqr_pkg::CFG_SPEED_G:   r_speed_g <= i_cfg.data;
                palqr_pkg::CFG_INT_G:     r_int_g   <= i_cfg.data;
                palqr_pkg::CFG_FF:        r_ff      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= palqr_pkg::S_IDLE;
            r_target  <= 16'sd0;
            r_isum    <= 32'sd0;
            r_startup <= 8'd0;
            r_skip    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                palqr_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_link_ok     <= i_in.link_ok;
                        r_referee     <= i_in.referee_link;
                        r_stick       <= i_in.stick_ud;
                        r_mouse_du    <= i_in.mouse_du;
                        r_mouse_pitch <= i_in.mouse_pitch;
                        r_vreq        <= i_in.vision_request;
                        r_vision      <= i_in.vision_pitch;
                        r_pos         <= i_in.motor_position;
                        r_speed       <= i_in.motor_speed;
                        if (!r_skip && i_in.link_started) begin
                            r_t <= 28'sd0;
                        end else begin
                            r_t <= {{12{r_target[15]}}, r_target};
                        end
                        if (r_skip) begin
                            r_skip <= 1'b0;
                        end else if (i_in.link_started) begin
                            r_startup <= 8'd0;
                        end
                        r_state <= palqr_pkg::S_STEP1;
                    end
                end
                palqr_pkg::S_STEP1: begin
                    if (!r_link_ok) begin
                        r_skip  <= 1'b1;
                        r_state <= palqr_pkg::S_CLAMP;
                    end else if (!move) begin
                        r_state <= palqr_pkg::S_CLAMP;
                    end else if (r_mouse_pitch == 16'd0) begin
                        r_state <= palqr_pkg::S_S2;
                    end else begin
                        r_state <= palqr_pkg::S_M2;
                    end
                end
                palqr_pkg::S_S2: begin
                    r_state <= palqr_pkg::S_S3;
                end
                palqr_pkg::S_S3: begin
                    r_t     <= r_t - $signed(step_s[27:0]);
                    r_state <= palqr_pkg::S_CLAMP;
                end
                palqr_pkg::S_M2: begin
                    r_aux   <= r_prod[27:0];
                    r_state <= palqr_pkg::S_M3;
                end
                palqr_pkg::S_M3: begin
                    r_state <= palqr_pkg::S_M4;
                end
                palqr_pkg::S_M4: begin
                    r_t     <= r_t + $signed(step_m[27:0]);
                    r_state <= palqr_pkg::S_CLAMP;
                end
                palqr_pkg::S_CLAMP: begin
                    r_target <= tv[15:0];
                    r_state  <= palqr_pkg::S_I1;
                end
                palqr_pkg::S_I1: begin
                    r_err   <= err;
                    r_fade  <= fade;
                    r_state <= palqr_pkg::S_I2;
                end
                palqr_pkg::S_I2: begin
                    r_state <= palqr_pkg::S_I3;
                end
                palqr_pkg::S_I3: begin
                    r_x     <= div_sum[43:16];
                    r_neg   <= r_prod[61];
                    r_state <= palqr_pkg::S_DIV;
                end
                palqr_pkg::S_DIV: begin
                    r_state <= palqr_pkg::S_I4;
                end
                palqr_pkg::S_I4: begin
                    r_isum  <= isum32;
                    r_acc   <= $signed({{4{isum32[31]}}, isum32, 4'd0})
                               - $signed({{16{r_ff[15]}}, r_ff, 8'd0});
                    r_state <= palqr_pkg::S_A1;
                end
                palqr_pkg::S_A1: begin
                    r_acc   <= r_acc + r_prod[39:0];
                    r_state <= palqr_pkg::S_A2;
                end
                palqr_pkg::S_A2: begin
                    r_acc   <= r_acc - $signed({r_prod[35:0], 4'd0});
                    r_state <= palqr_pkg::S_OUT;
                end
                palqr_pkg::S_OUT: begin
                    if (out_load) begin
                        r_tgt_out <= r_target;
                        if (r_startup > palqr_pkg::STARTUP_TICKS) begin
                            r_torque <= tq[15:0];
                            r_en     <= 1'b1;
                        end else begin
                            if (r_startup != 8'hFF) begin
                                r_startup <= r_startup + 8'd1;
                            end
                            r_torque <= 16'd0;
                            r_en     <= 1'b0;
                        end
                        r_state <= palqr_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= palqr_pkg::S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == palqr_pkg::S_STEP1))
        else $error("Accepted request did not start the tick sequence.");

    a_torque_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.torque) <= 16'sd20480
                         && $signed(o_out.torque) >= -16'sd20480))
        else $error("Torque result is outside the torque limit.");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.drive_enabled) |-> (o_out.torque == 16'd0))
        else $error("Torque is nonzero while the drive is held off.");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == palqr_pkg::S_I1) && $stable(r_amin) && $stable(r_amax)
         && ($signed(r_amin) <= $signed(r_amax)))
        |-> (($signed(r_target) >= $signed(r_amin)) && ($signed(r_target) <= $signed(r_amax))))
        else $error("Clamped target lies outside the angle limits.");

    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == palqr_pkg::S_I4) |-> ($past(r_state) == palqr_pkg::S_DIV))
        else $error("Integral update was reached without the reciprocal multiply.");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the pitch axis state feedback controller.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        link_ok;
        logic        link_started;
        logic        referee_link;
        logic [10:0] stick_ud;
        logic [15:0] mouse_du;
        logic [15:0] mouse_pitch;
        logic        vision_request;
        logic [15:0] vision_pitch;
        logic [15:0] motor_position;
        logic [15:0] motor_speed;
    } t_pitch_tick;

    typedef struct {
        logic [15:0] torque;
        logic [15:0] target_angle;
        logic        drive_enabled;
    } t_pitch_result;

    localparam longint STICK_UP_TH   = 1050;
    localparam longint STICK_DOWN_TH = 1000;
    localparam longint STICK_CENTER  = 1024;
    localparam longint STICK_STEP    = 312;
    localparam longint MOUSE_STEP    = 624;
    localparam longint ERR_5DEG      = 357;
    localparam longint ERR_15DEG     = 1072;
    localparam longint ERR_20DEG     = 1430;
    localparam longint TORQUE_MAX    = 20480;
    localparam longint INTEG_MAX     = 64'sd2147483647;
    localparam longint INTEG_MIN     = -64'sd2147483648;

    logic i_clk;
    logic i_rst_n;

    palqr_in_if  in_if ();
    palqr_out_if out_if ();
    palqr_cfg_if cfg_if ();

    pitch_axis_lqr_integral_control u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor copy of the registers and the controller state.
    logic [15:0] lim_lo   = palqr_pkg::RST_ANGLE_MIN;
    logic [15:0] lim_hi   = palqr_pkg::RST_ANGLE_MAX;
    logic [15:0] stick_k  = palqr_pkg::RST_STICK_G;
    logic [15:0] mouse_k  = palqr_pkg::RST_MOUSE_G;
    logic [15:0] pos_k    = palqr_pkg::RST_POS_G;
    logic [15:0] speed_k  = palqr_pkg::RST_SPEED_G;
    logic [15:0] integ_k  = palqr_pkg::RST_INT_G;
    logic [15:0] ff_k     = palqr_pkg::RST_FF;
    longint      target_st  = 0;
    int          integ_st   = 0;
    int          startup_st = 0;
    bit          skip_st    = 1'b0;

    t_pitch_tick   pending_ticks[$];
    t_pitch_result expected_outputs[$];

    int err_count    = 0;
    int results_seen = 0;
    bit in_taken     = 1'b0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int next_hold_at = 250;
    int ready_mode   = 0;
    int mode_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_pitch_result control_tick(t_pitch_tick tk);
        t_pitch_result r;
        longint t, lo, hi, stick, mouse, pc, pos, spd;
        longint err, mag, fade, iterm, isum, acc, tq;
        bit up, down, same;
        t     = target_st;
        lo    = longint'($signed(lim_lo));
        hi    = longint'($signed(lim_hi));
        stick = longint'(tk.stick_ud);
        mouse = longint'($signed(tk.mouse_du));
        pc    = longint'($signed(tk.mouse_pitch));
        pos   = longint'($signed(tk.motor_position));
        spd   = longint'($signed(tk.motor_speed));

        if (skip_st) begin
            skip_st = 1'b0;
        end else if (tk.link_started) begin
            startup_st = 0;
            t = 0;
        end

        if (!tk.link_ok) begin
            skip_st = 1'b1;
        end else begin
            up = ((stick > STICK_UP_TH && !tk.referee_link) || mouse < 0) && t > lo;
            down = ((stick < STICK_DOWN_TH && !tk.referee_link) || mouse > 0) && t < hi;
            if (up || down) begin
                if (pc == 0) begin
                    t -= round_div(longint'(stick_k) * (stick - STICK_CENTER) * STICK_STEP,
                                   64'sd65536);
                end else begin
                    t += round_div(longint'(stick_k) * pc * longint'(mouse_k) * MOUSE_STEP,
                                   64'sd1 << 32);
                end
            end
            if (tk.vision_request) begin
                t = longint'($signed(tk.vision_pitch));
            end
        end

        if (t < lo) t = lo;
        if (t > hi) t = hi;
        target_st = t;

        err = t - pos;
        mag = (err < 0) ? -err : err;
        fade = ERR_15DEG;
        same = (err > 0 && integ_st > 0) || (err < 0 && integ_st < 0);
        if (same) begin
            if (mag <= ERR_5DEG) fade = ERR_15DEG;
            else if (mag <= ERR_20DEG) fade = ERR_20DEG - mag;
            else fade = 0;
        end
        iterm = round_div(longint'(integ_k) * err * fade, ERR_15DEG * 4096);
        isum = longint'(integ_st) + iterm;
        if (isum > INTEG_MAX) isum = INTEG_MAX;
        if (isum < INTEG_MIN) isum = INTEG_MIN;
        integ_st = int'(isum);

        acc = -longint'($signed(ff_k)) * 256 + longint'(pos_k) * err + isum * 16
            - longint'(speed_k) * spd * 16;
        tq = round_div(acc, 256);
        if (tq > TORQUE_MAX) tq = TORQUE_MAX;
        if (tq < -TORQUE_MAX) tq = -TORQUE_MAX;

        if (startup_st > int'(palqr_pkg::STARTUP_TICKS)) begin
            r.torque = tq[15:0];
            r.drive_enabled = 1'b1;
        end else begin
            if (startup_st < 255) startup_st++;
            r.torque = 16'd0;
            r.drive_enabled = 1'b0;
        end
        r.target_angle = t[15:0];
        return r;
    endfunction

    // Input driver: bursts of requests separated by random gaps.
    always @(negedge i_clk) begin
        t_pitch_tick tk;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (gap_left > 0) begin
                in_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ticks.size() != 0) begin
                tk = pending_ticks.pop_front();
                in_if.valid          <= 1'b1;
                in_if.link_ok        <= tk.link_ok;
                in_if.link_started   <= tk.link_started;
                in_if.referee_link   <= tk.referee_link;
                in_if.stick_ud       <= tk.stick_ud;
                in_if.mouse_du       <= tk.mouse_du;
                in_if.mouse_pitch    <= tk.mouse_pitch;
                in_if.vision_request <= tk.vision_request;
                in_if.vision_pitch   <= tk.vision_pitch;
                in_if.motor_position <= tk.motor_position;
                in_if.motor_speed    <= tk.motor_speed;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern of its own, plus long hold-offs that back up the input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (results_seen >= next_hold_at) begin
            out_if.ready <= 1'b0;
            hold_left <= 400;
            next_hold_at <= next_hold_at + 700;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 160);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= ($urandom_range(0, 1) == 0);
                2: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= ~out_if.ready;
            endcase
        end
    end

    // Monitor: register writes, accepted requests and checked results.
    always @(posedge i_clk) begin
        t_pitch_tick   tk;
        t_pitch_result want;
        in_taken <= in_if.valid && in_if.ready;
        if (cfg_if.valid && cfg_if.ready) begin
            unique case (palqr_pkg::t_cfg_idx'(cfg_if.index))
                palqr_pkg::CFG_ANGLE_MIN: lim_lo  = cfg_if.data;
                palqr_pkg::CFG_ANGLE_MAX: lim_hi  = cfg_if.data;
                palqr_pkg::CFG_STICK_G:   stick_k = cfg_if.data;
                palqr_pkg::CFG_MOUSE_G:   mouse_k = cfg_if.data;
                palqr_pkg::CFG_POS_G:     pos_k   = cfg_if.data;
                palqr_pkg::CFG_SPEED_G:   speed_k = cfg_if.data;
                palqr_pkg::CFG_INT_G:     integ_k = cfg_if.data;
                palqr_pkg::CFG_FF:        ff_k    = cfg_if.data;
                default: ;
            endcase
        end
        if (in_if.valid && in_if.ready) begin
            tk.link_ok        = in_if.link_ok;
            tk.link_started   = in_if.link_started;
            tk.referee_link   = in_if.referee_link;
            tk.stick_ud       = in_if.stick_ud;
            tk.mouse_du       = in_if.mouse_du;
            tk.mouse_pitch    = in_if.mouse_pitch;
            tk.vision_request = in_if.vision_request;
            tk.vision_pitch   = in_if.vision_pitch;
            tk.motor_position = in_if.motor_position;
            tk.motor_speed    = in_if.motor_speed;
            expected_outputs.push_back(control_tick(tk));
        end
        if (out_if.valid && out_if.ready) begin
            results_seen = results_seen + 1;
            if (expected_outputs.size() == 0) begin
                if (err_count < 10) begin
                    $display("unexpected result: torque %0d target %0d drive %0b",
                             $signed(out_if.torque), $signed(out_if.target_angle),
                             out_if.drive_enabled);
                end
                err_count = err_count + 1;
            end else begin
                want = expected_outputs.pop_front();
                if (out_if.torque !== want.torque || out_if.target_angle !== want.target_angle
                        || out_if.drive_enabled !== want.drive_enabled) begin
                    if (err_count < 10) begin
                        $display("result %0d mismatch: torque %0d/%0d target %0d/%0d drive %0b/%0b",
                                 results_seen, $signed(want.torque), $signed(out_if.torque),
                                 $signed(want.target_angle), $signed(out_if.target_angle),
                                 want.drive_enabled, out_if.drive_enabled);
                    end
                    err_count = err_count + 1;
                end
            end
        end
    end

    task automatic push_tick(bit ok, bit started, bit referee, int stick, int mouse, int pc,
                             bit vreq, int vpitch, int pos, int spd);
        t_pitch_tick tk;
        tk.link_ok        = ok;
        tk.link_started   = started;
        tk.referee_link   = referee;
        tk.stick_ud       = stick[10:0];
        tk.mouse_du       = mouse[15:0];
        tk.mouse_pitch    = pc[15:0];
        tk.vision_request = vreq;
        tk.vision_pitch   = vpitch[15:0];
        tk.motor_position = pos[15:0];
        tk.motor_speed    = spd[15:0];
        pending_ticks.push_back(tk);
    endtask

    function automatic int spread(int k);
        int v;
        v = $urandom_range(0, 2 * k);
        return v - k;
    endfunction

    function automatic int any16();
        return spread(32768);
    endfunction

    task automatic push_random_tick();
        int stick, mouse, pc, vpitch, pos, spd;
        case ($urandom_range(0, 3))
            0: stick = 1024 + spread(40);
            1: stick = $urandom_range(0, 2047);
            2: stick = ($urandom_range(0, 1) == 0) ? 0 : 2047;
            default: stick = $urandom_range(950, 1100);
        endcase
        case ($urandom_range(0, 3))
            0, 1: mouse = 0;
            2: mouse = spread(100);
            default: mouse = any16();
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pc = 0;
            4, 5, 6: pc = spread(200);
            default: pc = any16();
        endcase
        vpitch = ($urandom_range(0, 1) == 0) ? any16() : spread(3000);
        pos = ($urandom_range(0, 4) < 3) ? spread(2500) : any16();
        spd = ($urandom_range(0, 4) < 3) ? spread(500) : any16();
        push_tick($urandom_range(0, 19) != 0, $urandom_range(0, 24) == 0,
                  $urandom_range(0, 3) == 0, stick, mouse, pc,
                  $urandom_range(0, 9) == 0, vpitch, pos, spd);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || expected_outputs.size() != 0 || in_if.valid);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(palqr_pkg::t_cfg_idx idx, int val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[15:0];
        do @(posedge i_clk);
        while (!cfg_if.ready);
    endtask

    task automatic load_regs(int amin, int amax, int sg, int mg, int pg, int spg, int ig,
                             int ff);
        write_reg(palqr_pkg::CFG_ANGLE_MIN, amin);
        write_reg(palqr_pkg::CFG_ANGLE_MAX, amax);
        write_reg(palqr_pkg::CFG_STICK_G, sg);
        write_reg(palqr_pkg::CFG_MOUSE_G, mg);
        write_reg(palqr_pkg::CFG_POS_G, pg);
        write_reg(palqr_pkg::CFG_SPEED_G, spg);
        write_reg(palqr_pkg::CFG_INT_G, ig);
        write_reg(palqr_pkg::CFG_FF, ff);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        repeat (n) push_random_tick();
        wait_idle();
    endtask

    initial begin
        in_if.valid          = 1'b0;
        in_if.link_ok        = 1'b0;
        in_if.link_started   = 1'b0;
        in_if.referee_link   = 1'b0;
        in_if.stick_ud       = 11'd1024;
        in_if.mouse_du       = 16'd0;
        in_if.mouse_pitch    = 16'd0;
        in_if.vision_request = 1'b0;
        in_if.vision_pitch   = 16'd0;
        in_if.motor_position = 16'd0;
        in_if.motor_speed    = 16'd0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        i_rst_n              = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Startup hold with the default registers.
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 100, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, -100, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 400, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, -400, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 1000, 0);
        // Stick and mouse stepping, referee lockout, vision override.
        push_tick(1, 0, 0, 2047, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 1, 2047, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 1024, -32768, 32767, 0, 0, 0, 0);
        push_tick(1, 0, 0, 1024, 32767, -32768, 0, 0, 0, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 1, 32767, 0, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 1, -32768, 32767, -32768);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, -32768, 32767);
        // Link loss, then a link start that is skipped and one that takes effect.
        push_tick(0, 0, 0, 2047, -1, 5, 1, 1000, 0, 0);
        push_tick(1, 1, 0, 1024, 0, 0, 0, 0, 0, 0);
        push_tick(1, 1, 0, 1024, 0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 500, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, -1200, 0);
        push_tick(1, 0, 0, 1024, 0, 0, 0, 0, 3000, 0);
        push_tick(1, 1, 1, 2047, 32767, 32767, 1, 21845, -21846, 21845);
        wait_idle();
        run_random(150);

        load_regs(-32768, 32767, 65535, 65535, 65535, 65535, 65535, 20480);
        run_random(200);
        load_regs(0, 0, 0, 0, 0, 0, 0, -20480);
        run_random(100);
        load_regs(1500, -1500, 64, 64, 10240, 609, 9830, 4096);
        run_random(150);
        repeat (5) begin
            load_regs($urandom_range(0, 8000) - 8000, $urandom_range(0, 8000),
                      $urandom_range(0, 4000), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 4000),
                      $urandom_range(0, 65535), spread(20480));
            run_random(150);
        end
        load_regs(-2048, 2048, 64, 64, 10240, 609, 9830, 4096);
        run_random(200);

        repeat (40) @(posedge i_clk);
        if (expected_outputs.size() != 0) err_count = err_count + 1;
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
